@@ hdl/sha1md_pkg.sv @@
`timescale 1ns / 1ps

package sha1md_pkg;

    // Number of compression rounds and the width of the round counter.
    localparam int ROUNDS  = 80;
    localparam int ROUND_W = 7;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    // First padding byte after the message.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       is_last;
        logic       empty_msg;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_w0;
        logic [31:0] digest_w1;
        logic [31:0] digest_w2;
        logic [31:0] digest_w3;
        logic [31:0] digest_w4;
    } t_out_item;

    // Five 32-bit words: used for the chaining state and the working variables.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    localparam t_vars H_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476,
        e: 32'hc3d2e1f0
    };

    // Control for the block buffer and message schedule.
    typedef struct packed {
        logic        byte_we;
        logic        len_we;
        logic        shift;
        logic        first16;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic [63:0] len;
    } t_sched_ctl;

endpackage

@@ hdl/sha1_message_digest.sv @@
`timescale 1ns / 1ps

// SHA-1 digest of a byte stream. Each input beat carries one message byte;
// is_last marks the final byte and empty_msg ends the message at once with
// no byte added (on a fresh message this yields the digest of the empty
// message). The 64th byte of every block starts the compression, which holds
// off input: 80 rounds through the single shared round unit, one round per
// cycle, and then the fold of the working variables into the chaining state.
// Ending a message writes the padding bytes one at a time (the 0x80 marker
// and zeros up to byte 56, through a second block when fewer than nine bytes
// remain), then the length words, compresses each padding block and moves
// the digest into the output register. The digest comes out as one beat of
// five words, w0 most significant, after which the block restarts from the
// initial values. Input is stalled whenever the sequencer is not idle. The
// output register holds a finished digest while the next message streams in;
// a second digest waits in the sequencer until the first is taken.

module sha1_message_digest import sha1md_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_digest,
    input  logic      i_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_COMP,
        S_ADD,
        S_DONE
    } t_state;

    t_state             r_state,      n_state;
    t_state             r_after,      n_after;
    logic [ROUND_W-1:0] r_round,      n_round;
    logic [5:0]         r_pad_pos,    n_pad_pos;
    logic               r_first,      n_first;
    logic [60:0]        r_byte_total, n_byte_total;
    t_vars              r_chain,      n_chain;
    logic               r_o_valid,    n_o_valid;
    t_out_item          r_o_digest,   n_o_digest;

    logic       accept;
    logic       load;
    logic [5:0] pos;
    t_sched_ctl sched_ctl;
    logic [31:0] w;
    t_vars       vars;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign pos     = r_byte_total[5:0];

    // Buffer writes come from accepted bytes in idle, from padding and from the length words.
    always_comb begin
        sched_ctl         = '0;
        sched_ctl.shift   = (r_state == S_COMP);
        sched_ctl.first16 = (r_round < ROUND_W'(16));
        sched_ctl.len_we  = (r_state == S_LEN);
        sched_ctl.len     = {r_byte_total, 3'b000};
        if (r_state == S_PAD) begin
            sched_ctl.byte_we = 1'b1;
            sched_ctl.pos     = r_pad_pos;
            sched_ctl.data    = r_first ? PAD_BYTE : 8'h00;
        end else begin
            sched_ctl.byte_we = accept && !i_item.empty_msg;
            sched_ctl.pos     = pos;
            sched_ctl.data    = i_item.msg_byte;
        end
    end

    sha1md_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w)
    );

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_step  (r_state == S_COMP),
        .i_chain (r_chain),
        .i_w     (w),
        .i_round (r_round),
        .o_vars  (vars)
    );

    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_round      = r_round;
        n_pad_pos    = r_pad_pos;
        n_first      = r_first;
        n_byte_total = r_byte_total;
        n_chain      = r_chain;
        n_o_valid    = r_o_valid;
        n_o_digest   = r_o_digest;
        load         = 1'b0;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.empty_msg) begin
                        n_pad_pos = pos;
                        n_first   = 1'b1;
                        n_state   = S_PAD;
                    end else begin
                        n_byte_total = r_byte_total + 61'd1;
                        if (i_item.is_last) begin
                            n_pad_pos = pos + 6'd1;
                            n_first   = 1'b1;
                        end
                        if (pos == 6'd63) begin
                            // Full block: compress it, then pad if the message ended.
                            load    = 1'b1;
                            n_state = S_COMP;
                            n_after = i_item.is_last ? S_PAD : S_IDLE;
                        end else if (i_item.is_last) begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                n_pad_pos = r_pad_pos + 6'd1;
                n_first   = 1'b0;
                if (r_pad_pos == 6'd63) begin
                    // No room for the length: compress and pad a fresh block.
                    load    = 1'b1;
                    n_state = S_COMP;
                    n_after = S_PAD;
                end else if (r_pad_pos == 6'd55) begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                load    = 1'b1;
                n_state = S_COMP;
                n_after = S_DONE;
            end
            S_COMP: begin
                n_round = r_round + ROUND_W'(1);
                if (r_round == ROUND_W'(ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain.a = r_chain.a + vars.a;
                n_chain.b = r_chain.b + vars.b;
                n_chain.c = r_chain.c + vars.c;
                n_chain.d = r_chain.d + vars.d;
                n_chain.e = r_chain.e + vars.e;
                n_state   = r_after;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid            = 1'b1;
                    n_o_digest.digest_w0 = r_chain.a;
                    n_o_digest.digest_w1 = r_chain.b;
                    n_o_digest.digest_w2 = r_chain.c;
                    n_o_digest.digest_w3 = r_chain.d;
                    n_o_digest.digest_w4 = r_chain.e;
                    n_chain              = H_INIT;
                    n_byte_total         = '0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_round = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after      <= S_IDLE;
            r_round      <= '0;
            r_pad_pos    <= '0;
            r_first      <= 1'b0;
            r_byte_total <= '0;
            r_chain      <= H_INIT;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_after      <= n_after;
            r_round      <= n_round;
            r_pad_pos    <= n_pad_pos;
            r_first      <= n_first;
            r_byte_total <= n_byte_total;
            r_chain      <= n_chain;
            r_o_valid    <= n_o_valid;
        end
        r_o_digest <= n_o_digest;
    end

    assign o_valid  = r_o_valid;
    assign o_digest = r_o_digest;

`ifndef SYNTHESIS
    // The last round is always followed by the chaining update.
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) && (r_round == ROUND_W'(ROUNDS - 1)) |=> (r_state == S_ADD))
        else $error("compression did not end in the chaining update");

    // An empty-message beat goes straight to padding.
    a_empty_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.empty_msg |=> (r_state == S_PAD) && r_first)
        else $error("empty message did not start padding");

    // Delivering a digest restarts the message state.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (!r_o_valid || !i_stall)
        |=> r_o_valid && (r_byte_total == '0) && (r_chain == H_INIT))
        else $error("digest delivered without restarting the message state");
`endif

endmodule

@@ hdl/sha1md_sched.sv @@
`timescale 1ns / 1ps

module sha1md_sched import sha1md_pkg::*; (
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    output logic [31:0] o_w
);

    // Sixteen-word window. While bytes are packed it is the block buffer; during
    // compression it rotates so that word 0 is always the oldest schedule word.
    logic [31:0] r_w [16];
    logic [31:0] mix;
    logic [3:0]  idx;

    assign mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign o_w = i_ctl.first16 ? r_w[0] : {mix[30:0], mix[31]};
    assign idx = i_ctl.pos[5:2];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= o_w;
        end else if (i_ctl.len_we) begin
            r_w[14] <= i_ctl.len[63:32];
            r_w[15] <= i_ctl.len[31:0];
        end else if (i_ctl.byte_we) begin
            // The first byte of a word clears the rest of it.
            case (i_ctl.pos[1:0])
                2'd0:    r_w[idx]        <= {i_ctl.data, 24'd0};
                2'd1:    r_w[idx][23:16] <= i_ctl.data;
                2'd2:    r_w[idx][15:8]  <= i_ctl.data;
                default: r_w[idx][7:0]   <= i_ctl.data;
            endcase
        end
    end

endmodule

@@ hdl/sha1md_round.sv @@
`timescale 1ns / 1ps

module sha1md_round import sha1md_pkg::*; (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  t_vars              i_chain,
    input  logic [31:0]        i_w,
    input  logic [ROUND_W-1:0] i_round,
    output t_vars              o_vars
);

    t_vars       r_vars;
    t_vars       n_vars;
    logic [31:0] f;
    logic [31:0] k;

    always_comb begin
        case (i_round) inside
            [7'd0:7'd19]: begin
                f = (r_vars.b & r_vars.c) | (~r_vars.b & r_vars.d);
                k = K_0;
            end
            [7'd20:7'd39]: begin
                f = r_vars.b ^ r_vars.c ^ r_vars.d;
                k = K_1;
            end
            [7'd40:7'd59]: begin
                f = (r_vars.b & r_vars.c) | (r_vars.b & r_vars.d) | (r_vars.c & r_vars.d);
                k = K_2;
            end
            default: begin
                f = r_vars.b ^ r_vars.c ^ r_vars.d;
                k = K_3;
            end
        endcase
        n_vars.a = {r_vars.a[26:0], r_vars.a[31:27]} + f + r_vars.e + k + i_w;
        n_vars.b = r_vars.a;
        n_vars.c = {r_vars.b[1:0], r_vars.b[31:2]};
        n_vars.d = r_vars.c;
        n_vars.e = r_vars.d;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vars <= i_chain;
        end else if (i_step) begin
            r_vars <= n_vars;
        end
    end

    assign o_vars = r_vars;

endmodule

@@ sim/sha1_digest_checker.sv @@
`timescale 1ns / 1ps

module sha1_digest_checker import sha1md_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_digest,
    output int        o_fail_count,
    output int        o_pending
);

    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [60:0] byte_count;
    t_out_item   digests_due [$];
    int          fails = 0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic load_initial_hash();
        chain[0] = H_INIT.a;
        chain[1] = H_INIT.b;
        chain[2] = H_INIT.c;
        chain[3] = H_INIT.d;
        chain[4] = H_INIT.e;
    endtask

    // The schedule words overwrite the block buffer in place; the block rotates its window instead.
    task automatic compress_block();
        logic [31:0] a, b, c, d, e, f, k, sched, tmp;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < ROUNDS; t++) begin
            if (t < 16) begin
                sched = blk[t];
            end else begin
                sched = rotl(blk[(t + 13) % 16] ^ blk[(t + 8) % 16] ^
                             blk[(t + 2) % 16] ^ blk[t % 16], 1);
                blk[t % 16] = sched;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            tmp = rotl(a, 5) + f + e + k + sched;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endtask

    // Bytes pack big-endian; the first byte of a word clears the rest of it.
    task automatic store_byte(input int pos, input logic [7:0] data);
        if (pos % 4 == 0) begin
            blk[pos / 4] = {data, 24'h000000};
        end else begin
            blk[pos / 4] = blk[pos / 4] | (32'(data) << (8 * (3 - pos % 4)));
        end
    endtask

    task automatic close_message();
        int          pos;
        logic [63:0] bit_len;
        t_out_item   digest;
        pos     = int'(byte_count[5:0]);
        bit_len = {byte_count, 3'b000};
        store_byte(pos, PAD_BYTE);
        pos++;
        // Too little room for the length: pad out and compress an extra block.
        if (pos > 56) begin
            while (pos < 64) begin
                store_byte(pos, 8'h00);
                pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            store_byte(pos, 8'h00);
            pos++;
        end
        blk[14] = bit_len[63:32];
        blk[15] = bit_len[31:0];
        compress_block();
        digest = {chain[0], chain[1], chain[2], chain[3], chain[4]};
        digests_due.push_back(digest);
        load_initial_hash();
        byte_count = '0;
    endtask

    task automatic absorb_beat(input t_in_item beat);
        int pos;
        if (beat.empty_msg) begin
            close_message();
        end else begin
            pos = int'(byte_count[5:0]);
            store_byte(pos, beat.msg_byte);
            byte_count = byte_count + 1'b1;
            if (pos == 63) begin
                compress_block();
            end
            if (beat.is_last) begin
                close_message();
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            load_initial_hash();
            for (int j = 0; j < 16; j++) begin
                blk[j] = '0;
            end
            byte_count = '0;
            digests_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (digests_due.size() == 0) begin
                    $display("%0t: expected no digest, got %h", $time, i_out_digest);
                    fails++;
                end else begin
                    want = digests_due.pop_front();
                    for (int j = 0; j < 5; j++) begin
                        if (i_out_digest[159 - 32 * j -: 32] !== want[159 - 32 * j -: 32]) begin
                            $display("%0t: digest word %0d expected %h, got %h", $time, j,
                                     want[159 - 32 * j -: 32],
                                     i_out_digest[159 - 32 * j -: 32]);
                            fails++;
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_beat(i_in_item);
            end
        end
        o_pending    <= digests_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ sim/sha1_message_digest_tb.sv @@
`timescale 1ns / 1ps

module sha1_message_digest_tb;
    import sha1md_pkg::*;

    // Beats to send in total before the drain. The directed part is about ten
    // beats, so the random part supplies roughly sixteen hundred.
    localparam int TOTAL_BEATS  = 1610;
    // Length of the long receiver hold-off. While it lasts the output register
    // and the sequencer both fill with digests and the block must stall input.
    localparam int HOLD_OFF     = 2000;
    // Longest message end: padding bytes, two compressions and the hand-off.
    localparam int DRAIN_CYCLES = 400;
    // The limit sits well above the slowest legal run, with every beat ending a
    // message under the longest waits.
    localparam int CYCLE_LIMIT  = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_item;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_digest;
    logic      i_stall;

    int fail_count;
    int digests_pending;
    int cycle_count = 0;
    int beats_sent  = 0;

    sha1_message_digest uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_digest (o_digest),
        .i_stall  (i_stall)
    );

    // The checker keeps its own copy of the hash state, follows every accepted
    // input beat and compares each accepted digest against its prediction.
    sha1_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_digest (o_digest),
        .o_fail_count (fail_count),
        .o_pending    (digests_pending)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // In a burst the sender offers back-to-back beats; otherwise it idles a
    // random number of cycles before each beat.
    function automatic int pick_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // Lengths around the padding boundaries: 55 bytes still leaves room for
    // the length in the same block, 56 to 63 force a second padding block,
    // and 64 fills a block exactly so that padding starts a fresh one.
    function automatic int boundary_length(input int sel);
        case (sel)
            0: return 55;
            1: return 56;
            2: return 57;
            3: return 63;
            4: return 64;
            5: return 65;
            6: return 119;
            7: return 120;
            default: return 128;
        endcase
    endfunction

    // Offers one beat and returns at the clock edge where it is taken. The
    // valid is only lowered when a gap follows, so back-to-back beats never
    // see valid dropped and raised in the same step.
    task automatic send_beat(input logic [7:0] data, input logic last, input logic empty,
                             input int gap);
        t_in_item beat;
        beat.msg_byte  = data;
        beat.is_last   = last;
        beat.empty_msg = empty;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= beat;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
    endtask

    // Sends a message of random bytes. It ends either with is_last on its
    // final byte or with a separate empty-message beat, which closes the
    // message as received so far. A zero-length message always ends that way.
    // Non-final bytes may carry is_last too, which simply splits the message.
    task automatic send_message(input int len, input bit close_by_flag, input bit burst);
        for (int n = 0; n < len; n++) begin
            send_beat(8'($urandom_range(0, 255)),
                      (n == len - 1 && !close_by_flag) || ($urandom_range(0, 99) == 0),
                      1'b0, pick_gap(burst));
        end
        if (close_by_flag || len == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                      pick_gap(burst));
        end
    endtask

    // Digest side. The receiver stalls a random number of cycles before each
    // digest, takes every third stretch of a dozen digests without stalling,
    // and twice holds off for a long stretch while the sender keeps going.
    initial begin : digest_sink
        int hold;
        int taken;
        i_stall = 1'b0;
        taken   = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, 9);
            if ((taken / 12) % 3 == 2) begin
                hold = 0;
            end
            if (taken == 8 || taken == 40) begin
                hold = HOLD_OFF;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin : stimulus
        int  len;
        int  sel;
        bit  burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats. An empty-message beat wins over a byte marked last,
        // so the first two beats both give the digest of the empty message.
        send_beat(8'hff, 1'b1, 1'b1, 0);
        send_beat(8'h00, 1'b0, 1'b1, 0);
        // One-byte messages at both extremes of the byte.
        send_beat(8'h00, 1'b1, 1'b0, 0);
        send_beat(8'hff, 1'b1, 1'b0, 3);
        // The classic three-byte message.
        send_beat(8'h61, 1'b0, 1'b0, 0);
        send_beat(8'h62, 1'b0, 1'b0, 1);
        send_beat(8'h63, 1'b1, 1'b0, 0);
        // Empty-message beat in the middle of a message ends it with no byte
        // added; its own byte and last flag are ignored.
        send_beat(8'h80, 1'b0, 1'b0, 0);
        send_beat(8'h7f, 1'b0, 1'b0, 2);
        send_beat(8'h55, 1'b1, 1'b1, 0);

        // Random messages, mostly short so that many digests come out, with a
        // good share sitting on the padding boundaries and a few spanning
        // two or more blocks.
        while (beats_sent < TOTAL_BEATS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1:    len = 0;
                2, 3, 4: len = $urandom_range(1, 20);
                5, 6:    len = boundary_length($urandom_range(0, 8));
                7:       len = $urandom_range(1, 140);
                default: len = $urandom_range(20, 70);
            endcase
            burst = ($urandom_range(0, 3) == 0);
            send_message(len, $urandom_range(0, 4) == 0, burst);
        end
        i_valid <= 1'b0;

        // The checker updates its count at the edge where the last beat was
        // taken, so wait for the next edge before reading it.
        @(posedge i_clk);
        while (digests_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
